@@ rtl/core/piecewise_linear_interpolator_assert.svh @@
// Assertion macros for the piecewise linear interpolator.
// Used by the top level; no other dependencies.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define PLI_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PLI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/pli_pkg.sv @@
// Shared types and constants for the piecewise linear interpolator.
// No dependencies.
package pli_pkg;
  localparam int unsigned MaxPoints = 16;
  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam int unsigned CntW = 5;

  localparam logic       ReqLoad  = 1'b0;
  localparam logic       ReqQuery = 1'b1;
  localparam logic [1:0] StInside = 2'd0;
  localparam logic [1:0] StBelow  = 2'd1;
  localparam logic [1:0] StAbove  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_FIRST, S_CHK_FIRST, S_RD_LAST, S_CHK_LAST,
    S_SCAN, S_SCAN_CHK, S_RD_SEG, S_DIV, S_MUL, S_MUL_HI, S_ADD, S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic            load_query;  // capture query x
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            seg_lo;      // latch read data as segment start
    logic            seg_hi;      // latch read data as segment end
    logic            div_start;
    logic            div_step;
    logic            mul_go;      // low half of slope times dq
    logic            mul_hi;      // high half, accumulated
    logic            add_go;
    logic            res_clamp;   // result from read y
    logic [1:0]      res_status;
    logic            res_load;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic q_le_x;    // query <= read x
    logic q_ge_x;    // query >= read x
    logic div_done;
  } stat_t;
endpackage

@@ rtl/core/pli_datapath.sv @@
// Datapath: breakpoint memory, serial divider, two-pass multiplier, saturation.
// Depends on pli_pkg.
module pli_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [pli_pkg::IdxW-1:0]  wr_addr_i,
  input  logic signed [31:0]        wr_x_i,
  input  logic signed [31:0]        wr_y_i,
  input  logic signed [31:0]        query_x_i,
  input  pli_pkg::ctrl_t            ctrl_i,
  output pli_pkg::stat_t            stat_o,
  output logic signed [31:0]        result_o,
  output logic [1:0]                status_o
);
  logic signed [31:0] mem_x [pli_pkg::MaxPoints];
  logic signed [31:0] mem_y [pli_pkg::MaxPoints];
  logic signed [31:0] rd_x_q, rd_y_q, qx_q;
  logic signed [31:0] x0_q, y0_q, x1_q, y1_q;
  logic [48:0] rem_q;
  logic [48:0] quo_q;
  logic [32:0] dv_q;
  logic [5:0]  cnt_q;
  logic        neg_q, zero_q;
  logic signed [48:0] slope;
  logic signed [32:0] dq;
  logic signed [24:0] mul_a;
  logic signed [57:0] pp;
  logic signed [81:0] prod_q;
  logic signed [63:0] sum_q;
  logic [49:0] trial;
  logic signed [33:0] dx, dy;
  logic [48:0] ady;
  logic [32:0] adx;
  logic signed [63:0] clamped, fl;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_x[wr_addr_i] <= wr_x_i;
      mem_y[wr_addr_i] <= wr_y_i;
    end
    if (ctrl_i.rd_en) begin
      rd_x_q <= mem_x[ctrl_i.rd_addr];
      rd_y_q <= mem_y[ctrl_i.rd_addr];
    end
  end

  assign stat_o.q_le_x = (qx_q <= rd_x_q);
  assign stat_o.q_ge_x = (qx_q >= rd_x_q);
  assign stat_o.div_done = (cnt_q == 6'd0);

  // divider starts while the segment start is still on the read port
  assign dx  = 34'(x1_q) - 34'(rd_x_q);
  assign dy  = 34'(y1_q) - 34'(rd_y_q);
  assign adx = dx[33] ? 33'(-dx) : dx[32:0];
  assign ady = {(dy[33] ? 33'(-dy) : dy[32:0]), 16'd0};
  assign trial = {rem_q, quo_q[48]} - {17'd0, dv_q};
  assign slope = neg_q ? -$signed(quo_q) : $signed(quo_q);
  assign dq = 33'(qx_q) - 33'(x0_q);

  // slope split at bit 24: low half unsigned, high half signed
  assign mul_a = ctrl_i.mul_hi ? $signed(slope[48:24]) : $signed({1'b0, slope[23:0]});
  assign pp    = mul_a * dq;

  // saturate products past 2^62, then floor shift
  always_comb begin
    if (prod_q > 82'sd4611686018427387904)       clamped = 64'sh4000_0000_0000_0000;
    else if (prod_q < -82'sd4611686018427387904) clamped = -64'sh4000_0000_0000_0000;
    else                                          clamped = 64'(prod_q);
    fl = clamped >>> 16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.div_start) begin
      cnt_q <= 6'd49;
    end else if (ctrl_i.div_step && cnt_q != 6'd0) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_query) qx_q <= query_x_i;
    if (ctrl_i.seg_lo) begin
      x0_q <= rd_x_q;
      y0_q <= rd_y_q;
    end
    if (ctrl_i.seg_hi) begin
      x1_q <= rd_x_q;
      y1_q <= rd_y_q;
    end
    if (ctrl_i.div_start) begin
      rem_q  <= '0;
      quo_q  <= ady;
      dv_q   <= adx;
      neg_q  <= dx[33] ^ dy[33];
      zero_q <= (dx == 34'sd0);
    end else if (ctrl_i.div_step && cnt_q != 6'd0) begin
      if (!trial[49]) rem_q <= trial[48:0];
      else            rem_q <= {rem_q[47:0], quo_q[48]};
      quo_q <= {quo_q[47:0], ~trial[49]};
    end
    if (ctrl_i.mul_go)      prod_q <= 82'(pp);
    else if (ctrl_i.mul_hi) prod_q <= prod_q + (82'(pp) <<< 24);
    if (ctrl_i.add_go) sum_q <= 64'(y0_q) + fl;
    if (ctrl_i.res_load) begin
      status_o <= ctrl_i.res_status;
      if (ctrl_i.res_clamp) result_o <= rd_y_q;
      else if (zero_q)      result_o <= y0_q;
      else if (sum_q > 64'sd2147483647)  result_o <= 32'sh7fff_ffff;
      else if (sum_q < -64'sd2147483648) result_o <= 32'sh8000_0000;
      else result_o <= 32'(sum_q);
    end
  end
endmodule

@@ rtl/core/pli_ctrl.sv @@
// Controller state machine: clamp checks, segment scan, divide sequencing.
// Depends on pli_pkg.
module pli_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [pli_pkg::CntW-1:0] count_i,
  input  pli_pkg::stat_t           stat_i,
  input  logic                     out_free_i,
  output logic                     busy_o,
  output logic                     done_o,
  output pli_pkg::ctrl_t           ctrl_o
);
  pli_pkg::state_e state_q, state_d;
  logic [pli_pkg::IdxW-1:0] k_q, k_d, last;
  logic       clamp_q, clamp_d;
  logic [1:0] st_q, st_d;

  always_comb begin
    if (count_i < pli_pkg::CntW'(2)) last = pli_pkg::IdxW'(1);
    else if (count_i > pli_pkg::CntW'(pli_pkg::MaxPoints))
      last = pli_pkg::IdxW'(pli_pkg::MaxPoints - 1);
    else last = pli_pkg::IdxW'(count_i - pli_pkg::CntW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pli_pkg::S_IDLE;
      k_q <= '0;
      clamp_q <= 1'b0;
      st_q <= pli_pkg::StInside;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      clamp_q <= clamp_d;
      st_q <= st_d;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    clamp_d = clamp_q;
    st_d = st_q;
    unique case (state_q)
      pli_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = pli_pkg::S_RD_FIRST;
          clamp_d = 1'b0;
          st_d = pli_pkg::StInside;
        end
      end
      pli_pkg::S_RD_FIRST:  state_d = pli_pkg::S_CHK_FIRST;
      pli_pkg::S_CHK_FIRST: begin
        if (stat_i.q_le_x) begin
          clamp_d = 1'b1;
          st_d = pli_pkg::StBelow;
          state_d = pli_pkg::S_OUT;
        end else begin
          state_d = pli_pkg::S_RD_LAST;
        end
      end
      pli_pkg::S_RD_LAST:   state_d = pli_pkg::S_CHK_LAST;
      pli_pkg::S_CHK_LAST: begin
        k_d = pli_pkg::IdxW'(1);
        if (stat_i.q_ge_x) begin
          clamp_d = 1'b1;
          st_d = pli_pkg::StAbove;
          state_d = pli_pkg::S_OUT;
        end else begin
          state_d = pli_pkg::S_SCAN;
        end
      end
      pli_pkg::S_SCAN:      state_d = pli_pkg::S_SCAN_CHK;
      pli_pkg::S_SCAN_CHK: begin
        if (stat_i.q_le_x || k_q == last) state_d = pli_pkg::S_RD_SEG;
        else begin
          k_d = k_q + pli_pkg::IdxW'(1);
          state_d = pli_pkg::S_SCAN;
        end
      end
      pli_pkg::S_RD_SEG:    state_d = pli_pkg::S_DIV;
      pli_pkg::S_DIV:       if (stat_i.div_done) state_d = pli_pkg::S_MUL;
      pli_pkg::S_MUL:       state_d = pli_pkg::S_MUL_HI;
      pli_pkg::S_MUL_HI:    state_d = pli_pkg::S_ADD;
      pli_pkg::S_ADD:       state_d = pli_pkg::S_OUT;
      pli_pkg::S_OUT:       if (out_free_i) state_d = pli_pkg::S_IDLE;
      default:              state_d = pli_pkg::S_IDLE;
    endcase
  end

  // S_SCAN_CHK latches x[k] as segment end; S_RD_SEG latches x[k-1] as start
  always_comb begin
    ctrl_o = '0;
    busy_o = (state_q != pli_pkg::S_IDLE);
    done_o = 1'b0;
    unique case (state_q)
      pli_pkg::S_IDLE:     ctrl_o.load_query = start_i;
      pli_pkg::S_RD_FIRST: begin
        ctrl_o.rd_en = 1'b1;
        ctrl_o.rd_addr = '0;
      end
      pli_pkg::S_CHK_FIRST: begin
        // keep y[0] on the read port when clamping below
        ctrl_o.rd_en = ~stat_i.q_le_x;
        ctrl_o.rd_addr = last;
      end
      pli_pkg::S_SCAN: begin
        ctrl_o.rd_en = 1'b1;
        ctrl_o.rd_addr = k_q;
      end
      pli_pkg::S_SCAN_CHK: begin
        ctrl_o.seg_hi = 1'b1;
        ctrl_o.rd_en = 1'b1;
        ctrl_o.rd_addr = k_q - pli_pkg::IdxW'(1);
      end
      pli_pkg::S_RD_SEG: begin
        ctrl_o.seg_lo = 1'b1;
        ctrl_o.div_start = 1'b1;
      end
      pli_pkg::S_DIV: begin
        ctrl_o.div_step = 1'b1;
      end
      pli_pkg::S_MUL:    ctrl_o.mul_go = 1'b1;
      pli_pkg::S_MUL_HI: ctrl_o.mul_hi = 1'b1;
      pli_pkg::S_ADD:    ctrl_o.add_go = 1'b1;
      pli_pkg::S_OUT: begin
        ctrl_o.res_load = out_free_i;
        ctrl_o.res_clamp = clamp_q;
        ctrl_o.res_status = st_q;
        done_o = out_free_i;
      end
      default: ;
    endcase
  end
endmodule

@@ rtl/core/piecewise_linear_interpolator.sv @@
// Piecewise linear interpolator over a 16-entry Q16.16 breakpoint table.
// A load word (req_type 0) writes one breakpoint and gives no result. A
// query word walks the table: two reads for the end clamps, then a read and
// a check per segment visited, then a restoring divider of 49 steps for the
// slope, a multiply in two halves and one add. Clamped queries skip the scan,
// divide, multiply and add and go straight to the output state; output stalls
// hold a query in that state. One query is in flight at a time; the result
// sits in an output register until taken.
// Depends on pli_pkg, pli_ctrl, pli_datapath and the assertion header.
`include "piecewise_linear_interpolator_assert.svh"
module piecewise_linear_interpolator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [4:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] query_x_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]         range_status_o
);
  logic [pli_pkg::CntW-1:0] count_q;
  logic busy, done, accept, out_valid_q, res_hold;
  pli_pkg::ctrl_t ctrl;
  pli_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  // output register may be overwritten only once the old word is gone
  assign res_hold = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= pli_pkg::CntW'(2);
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  // every query, clamped or not, finishes through S_OUT
  pli_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i   (accept && req_type_i == pli_pkg::ReqQuery),
    .count_i   (count_q),
    .stat_i    (stat),
    .out_free_i(!res_hold),
    .busy_o    (busy),
    .done_o    (done),
    .ctrl_o    (ctrl)
  );

  pli_datapath u_dp (
    .clk_i, .rst_ni,
    .wr_en_i  (accept && req_type_i == pli_pkg::ReqLoad),
    .wr_addr_i(entry_index_i),
    .wr_x_i   (point_x_i),
    .wr_y_i   (point_y_i),
    .query_x_i(query_x_i),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .result_o (result_value_o),
    .status_o (range_status_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  `PLI_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, busy, !accept)
  `PLI_ASSERT_NEXT(a_done_valid, clk_i, rst_ni, done, out_valid_o)
  `PLI_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, res_hold, !done)
endmodule

@@ test/piecewise_linear_interpolator_tb.sv @@
// Self-checking testbench for piecewise_linear_interpolator: loads breakpoint
// tables, queries them and checks every result against an in-bench predictor.
// Depends on pli_pkg and the piecewise_linear_interpolator RTL.
`timescale 1ns / 1ps

module piecewise_linear_interpolator_tb;

  typedef struct {
    logic               req;
    logic [3:0]         idx;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] qx;
  } word_t;

  typedef struct {
    logic signed [31:0] val;
    logic [1:0]         st;
  } result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [4:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               req_type_i = pli_pkg::ReqLoad;
  logic [3:0]         entry_index_i = '0;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic signed [31:0] query_x_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] result_value_o;
  logic [1:0]         range_status_o;

  // pending stimulus words and predicted results, oldest first
  word_t   pending_words[$];
  result_t expected_results[$];

  // predictor copy of the table and of point_count
  logic signed [31:0] tab_x[pli_pkg::MaxPoints];
  logic signed [31:0] tab_y[pli_pkg::MaxPoints];
  logic [4:0]         point_count;

  int  errors = 0;
  int  queries_done = 0;
  int  loads_done = 0;
  int  results_seen = 0;
  int  clamp_seen[3] = '{0, 0, 0};
  int  in_gap = 0;
  int  out_gap = 0;
  bit  quiet = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  piecewise_linear_interpolator i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .req_type_i,
    .entry_index_i,
    .point_x_i,
    .point_y_i,
    .query_x_i,
    .out_valid_o,
    .out_stall_i,
    .result_value_o,
    .range_status_o
  );

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Interpolated value at qx for the current table and point_count.
  function automatic result_t interpolate_at(input logic signed [31:0] qx);
    result_t r;
    int n;
    int k;
    longint x0, x1, y0, y1, dx, slope, dq, sum;
    logic signed [127:0] a, b, prod;
    n = (point_count < 2) ? 2 :
        ((point_count > pli_pkg::MaxPoints) ? pli_pkg::MaxPoints : point_count);
    // below clamp is checked first, so it wins when both apply
    if (qx <= tab_x[0]) begin
      r.val = tab_y[0];
      r.st = pli_pkg::StBelow;
      return r;
    end
    if (qx >= tab_x[n-1]) begin
      r.val = tab_y[n-1];
      r.st = pli_pkg::StAbove;
      return r;
    end
    r.st = pli_pkg::StInside;
    k = 0;
    while (k < n - 1 && qx > tab_x[k+1]) k++;
    if (k > n - 2) k = n - 2;
    x0 = tab_x[k];
    x1 = tab_x[k+1];
    y0 = tab_y[k];
    y1 = tab_y[k+1];
    dx = x1 - x0;
    if (dx == 0) begin
      r.val = tab_y[k];
      return r;
    end
    slope = ((y1 - y0) * 64'sd65536) / dx;  // truncates toward zero
    dq = longint'(qx) - x0;
    a = slope;
    b = dq;
    prod = a * b;
    // product clamps at +/-2^62 before the floor shift
    if (prod > 128'sh4000_0000_0000_0000) prod = 128'sh4000_0000_0000_0000;
    if (prod < -128'sh4000_0000_0000_0000) prod = -128'sh4000_0000_0000_0000;
    prod = prod >>> 16;
    sum = y0 + longint'(prod);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    r.val = sum[31:0];
    return r;
  endfunction

  // Driver: presents queued words, updates the predictor on acceptance.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      if (req_type_i == pli_pkg::ReqLoad) begin
        tab_x[entry_index_i] = point_x_i;
        tab_y[entry_index_i] = point_y_i;
        loads_done++;
      end else begin
        expected_results.push_back(interpolate_at(query_x_i));
        queries_done++;
      end
    end
    if (!in_valid_i || !in_stall_o) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 9);  // this cycle plus the rest of the burst
        in_valid_i <= 1'b0;
      end else begin
        word_t w;
        w = pending_words.pop_front();
        in_valid_i    <= 1'b1;
        req_type_i    <= w.req;
        entry_index_i <= w.idx;
        point_x_i     <= w.px;
        point_y_i     <= w.py;
        query_x_i     <= w.qx;
      end
    end
  end

  // Monitor: random output stalls, checks each taken result in order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h status %0d",
                                    result_value_o, range_status_o));
        end else begin
          result_t e;
          e = expected_results.pop_front();
          results_seen++;
          if (e.st < 3) clamp_seen[e.st]++;
          if (result_value_o !== e.val)
            report_mismatch($sformatf("result_value got %h want %h",
                                      result_value_o, e.val));
          if (range_status_o !== e.st)
            report_mismatch($sformatf("range_status got %0d want %0d",
                                      range_status_o, e.st));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 9);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic add_word(input logic rq, input logic [3:0] ix, input logic signed [31:0] x,
                          input logic signed [31:0] y, input logic signed [31:0] q);
    word_t w;
    w.req = rq;
    w.idx = ix;
    w.px = x;
    w.py = y;
    w.qx = q;
    pending_words.push_back(w);
  endtask

  // Sender pauses until every predicted result is back, then lets the block settle.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_point_count(input logic [4:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    point_count = v;
  endtask

  // One phase: a table of the given shape, then random queries and noise.
  // shape 0 increasing, 1 increasing with repeated x, 2 unordered
  task automatic run_phase(input logic [4:0] cnt, input int shape, input int n_items);
    int n;
    longint x, lo, hi;
    logic signed [31:0] qx;
    n = (cnt < 2) ? 2 : ((cnt > pli_pkg::MaxPoints) ? pli_pkg::MaxPoints : cnt);
    drain();
    write_point_count(cnt);
    x = -64'sd2147483648 + longint'($urandom_range(0, 32'h7fff_ffff));
    lo = x;
    for (int i = 0; i < n; i++) begin
      if (shape == 2) begin
        add_word(pli_pkg::ReqLoad, 4'(i), $urandom, $urandom, '0);
      end else begin
        if (i > 0 && !(shape == 1 && $urandom_range(0, 2) == 0))
          x += 1 + ($urandom_range(0, 32'h07ff_ffff) >> $urandom_range(0, 20));
        add_word(pli_pkg::ReqLoad, 4'(i), x[31:0], $urandom >> $urandom_range(0, 31) ^
                 (($urandom & 1) ? 32'hffff_ffff : 32'h0), '0);
      end
    end
    hi = x;
    for (int i = 0; i < n_items; i++) begin
      case ($urandom_range(0, 19))
        0: add_word(pli_pkg::ReqLoad, 4'($urandom), $urandom, $urandom, $urandom);  // stray
        1: add_word(pli_pkg::ReqQuery, 4'($urandom), $urandom, $urandom, $urandom); // any x
        default: begin
          qx = 32'(lo - 256 + longint'($urandom_range(0, 32'(hi - lo + 512))));
          add_word(pli_pkg::ReqQuery, 4'($urandom), $urandom, $urandom, qx);
        end
      endcase
    end
  endtask

  initial begin
    logic [4:0] counts[6];
    for (int i = 0; i < pli_pkg::MaxPoints; i++) begin
      tab_x[i] = '0;
      tab_y[i] = '0;
    end
    point_count = 5'd2;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: full-range two-point table, then every entry written
    add_word(pli_pkg::ReqLoad, 4'd0, 32'sh8000_0000, 32'sh7fff_ffff, '0);
    add_word(pli_pkg::ReqLoad, 4'd1, 32'sh7fff_ffff, 32'sh8000_0000, '0);
    add_word(pli_pkg::ReqQuery, 4'd0, '0, '0, 32'sh8000_0000);  // at first x
    add_word(pli_pkg::ReqQuery, 4'd0, '0, '0, 32'sh7fff_ffff);  // at last x
    add_word(pli_pkg::ReqQuery, 4'd0, '0, '0, 32'sh0000_0000);  // mid, steep negative slope
    add_word(pli_pkg::ReqQuery, 4'd0, '0, '0, 32'sh8000_0001);
    add_word(pli_pkg::ReqQuery, 4'd0, '0, '0, 32'sh7fff_fffe);
    for (int i = 2; i < pli_pkg::MaxPoints; i++)
      add_word(pli_pkg::ReqLoad, 4'(i), 32'(i * 32'h0001_0000), 32'(i * 32'h0003_0000), '0);
    // both clamps at once: first x above last x
    add_word(pli_pkg::ReqLoad, 4'd1, 32'sh8000_0000, 32'sh0000_1234, '0);
    add_word(pli_pkg::ReqLoad, 4'd0, 32'sh0001_0000, 32'sh0000_5678, '0);
    add_word(pli_pkg::ReqQuery, 4'd0, '0, '0, 32'sh0000_0000);
    add_word(pli_pkg::ReqQuery, 4'd0, '0, '0, 32'sh7000_0000);

    // several point_count settings, extremes and out-of-range values first
    counts = '{5'd0, 5'd31, 5'd2, 5'd16, 5'd1, 5'd17};
    for (int p = 0; p < 6; p++) run_phase(counts[p], p % 3, 110);
    for (int p = 0; p < 7; p++) run_phase(5'($urandom_range(0, 31)), $urandom_range(0, 2), 110);
    // last part runs without idling on either side
    drain();
    quiet = 1'b1;
    run_phase(5'd16, 0, 110);
    drain();

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("covered %0d loads, %0d queries, %0d results (inside %0d, below %0d, above %0d)",
             loads_done, queries_done, results_seen,
             clamp_seen[0], clamp_seen[1], clamp_seen[2]);
    if (errors == 0) begin
      $display("piecewise_linear_interpolator_tb: done, clean");
    end else begin
      $display("piecewise_linear_interpolator_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("piecewise_linear_interpolator_tb: done, errors");
    $finish;
  end

endmodule
